// ----- rtl/core/s4stu_pkg.sv -----
package s4stu_pkg;

   localparam int ELEM_W      = 64;
   localparam int ADDR_W      = 24;
   localparam int DIM_W       = 7;
   localparam int MAX_DIM_DEF = 64;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_DATA_W  = ELEM_W;
   localparam int RSP_DATA_W  = ADDR_W + ELEM_W;
   localparam int WRITES      = 4;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTER_DIM = 1'b0,
      CSR_INNER_DIM = 1'b1
   } csr_reg_type;

endpackage

// ----- rtl/core/s4stu_index.sv -----
module s4stu_index #(
   parameter  int MAX_DIM = s4stu_pkg::MAX_DIM_DEF,
   localparam int IDX_W   = $clog2(MAX_DIM),
   localparam int DIMX_W  = $clog2(MAX_DIM + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [s4stu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [s4stu_pkg::DIM_W-1:0]      csr_wdata,
   input  logic                             step,
   output logic [IDX_W-1:0]                 idx_i,
   output logic [IDX_W-1:0]                 idx_j,
   output logic [IDX_W-1:0]                 idx_k,
   output logic [IDX_W-1:0]                 idx_l,
   output logic [DIMX_W-1:0]                outer_eff,
   output logic [DIMX_W-1:0]                inner_eff
);
   import s4stu_pkg::*;

   localparam int CMP_W = (DIM_W > DIMX_W) ? DIM_W : DIMX_W;

   logic [DIM_W-1:0] outer_dim_ff;
   logic [DIM_W-1:0] inner_dim_ff;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff, l_ff;
   logic [IDX_W-1:0] i_in, j_in, k_in, l_in;

   // zero reads as one, anything past the maximum is clamped
   function automatic logic [DIMX_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
      logic [CMP_W-1:0] rx;
      rx = CMP_W'(r);
      if (r == '0) begin
         return DIMX_W'(1);
      end else if (rx > CMP_W'(MAX_DIM)) begin
         return DIMX_W'(MAX_DIM);
      end else begin
         return DIMX_W'(rx);
      end
   endfunction

   assign outer_eff = eff_dim(outer_dim_ff);
   assign inner_eff = eff_dim(inner_dim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_dim_ff <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            CSR_OUTER_DIM: outer_dim_ff <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      l_in = l_ff;
      if (step) begin
         if (l_ff < k_ff) begin
            l_in = l_ff + 1'b1;
         end else begin
            l_in = '0;
            if ((DIMX_W'(k_ff) + 1'b1) < inner_eff) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (j_ff < i_ff) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  if ((DIMX_W'(i_ff) + 1'b1) < outer_eff) begin
                     i_in = i_ff + 1'b1;
                  end else begin
                     i_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         l_ff <= '0;
      end else begin
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
         l_ff <= l_in;
      end
   end

   assign idx_i = i_ff;
   assign idx_j = j_ff;
   assign idx_k = k_ff;
   assign idx_l = l_ff;

endmodule

// ----- rtl/core/s4stu_addr.sv -----
module s4stu_addr #(
   parameter  int MAX_DIM = s4stu_pkg::MAX_DIM_DEF,
   localparam int IDX_W   = $clog2(MAX_DIM),
   localparam int DIMX_W  = $clog2(MAX_DIM + 1)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [s4stu_pkg::ELEM_W-1:0]               in_bits,
   input  logic [IDX_W-1:0]                           idx_i,
   input  logic [IDX_W-1:0]                           idx_j,
   input  logic [IDX_W-1:0]                           idx_k,
   input  logic [IDX_W-1:0]                           idx_l,
   input  logic [DIMX_W-1:0]                          outer_eff,
   input  logic [DIMX_W-1:0]                          inner_eff,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [s4stu_pkg::ELEM_W-1:0]               out_bits,
   output logic [s4stu_pkg::WRITES-1:0][s4stu_pkg::ADDR_W-1:0] out_addr
);
   import s4stu_pkg::*;

   localparam int XW = IDX_W + DIMX_W;
   localparam int SW = 2 * DIMX_W;

   // first stage: row terms (a*O + b), column terms (c*I + d), plane size I*I
   logic              x_valid_ff, x_valid_in;
   logic [ELEM_W-1:0] x_bits_ff;
   logic [XW-1:0]     xij_ff, xji_ff, ykl_ff, ylk_ff;
   logic [SW-1:0]     s_ff;
   // second stage: row term times plane size
   logic              p_valid_ff, p_valid_in;
   logic [ELEM_W-1:0] p_bits_ff;
   logic [ADDR_W-1:0] p0_ff, p1_ff;
   logic [XW-1:0]     pykl_ff, pylk_ff;

   logic p_free, x_free, nonzero;

   assign nonzero  = (in_bits[ELEM_W-2:0] != '0);
   assign p_free   = !p_valid_ff || out_ready;
   assign x_free   = !x_valid_ff || p_free;
   assign in_ready = x_free;

   always_comb begin
      x_valid_in = x_valid_ff;
      if (x_free) begin
         x_valid_in = in_valid && nonzero;
      end
      p_valid_in = p_valid_ff;
      if (p_free) begin
         p_valid_in = x_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && x_free) begin
         x_bits_ff <= in_bits;
         xij_ff    <= XW'(idx_i) * XW'(outer_eff) + XW'(idx_j);
         xji_ff    <= XW'(idx_j) * XW'(outer_eff) + XW'(idx_i);
         ykl_ff    <= XW'(idx_k) * XW'(inner_eff) + XW'(idx_l);
         ylk_ff    <= XW'(idx_l) * XW'(inner_eff) + XW'(idx_k);
         s_ff      <= SW'(inner_eff) * SW'(inner_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (x_valid_ff && p_free) begin
         p_bits_ff <= x_bits_ff;
         p0_ff     <= ADDR_W'(xij_ff) * ADDR_W'(s_ff);
         p1_ff     <= ADDR_W'(xji_ff) * ADDR_W'(s_ff);
         pykl_ff   <= ykl_ff;
         pylk_ff   <= ylk_ff;
      end
   end

   assign out_valid   = p_valid_ff;
   assign out_bits    = p_bits_ff;
   assign out_addr[0] = p0_ff + ADDR_W'(pykl_ff);
   assign out_addr[1] = p0_ff + ADDR_W'(pylk_ff);
   assign out_addr[2] = p1_ff + ADDR_W'(pylk_ff);
   assign out_addr[3] = p1_ff + ADDR_W'(pykl_ff);

endmodule

// ----- rtl/core/s4stu_emit.sv -----
module s4stu_emit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load_valid,
   output logic                                       load_ready,
   input  logic [s4stu_pkg::ELEM_W-1:0]               load_bits,
   input  logic [s4stu_pkg::WRITES-1:0][s4stu_pkg::ADDR_W-1:0] load_addr,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [s4stu_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                       rsp_tlast
);
   import s4stu_pkg::*;

   localparam int               CNT_W    = $clog2(WRITES);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WRITES - 1);

   logic                            em_valid_ff, em_valid_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [ELEM_W-1:0]               data_ff;
   logic [WRITES-1:0][ADDR_W-1:0]   addr_ff;
   logic                            last, xfer, load;

   assign last       = (cnt_ff == LAST_CNT);
   assign xfer       = em_valid_ff && rsp_tready;
   assign load_ready = !em_valid_ff || (xfer && last);
   assign load       = load_valid && load_ready;

   always_comb begin
      em_valid_in = em_valid_ff;
      cnt_in      = cnt_ff;
      if (xfer) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            em_valid_in = 1'b0;
         end
      end
      if (load) begin
         em_valid_in = 1'b1;
         cnt_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         em_valid_ff <= em_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_bits;
         addr_ff <= load_addr;
      end
   end

   assign rsp_tvalid = em_valid_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {data_ff, addr_ff[cnt_ff]};

endmodule

// ----- rtl/core/s4_symmetric_tensor_unpack.sv -----
// a nonzero element passes both register stages and the write sequencer before its first write
// a nonzero element gives four writes on the single write port, one per accepted transfer;
// later elements fill the stages meanwhile; zero elements move at one per cycle unless stalled
// the multiply path is two register stages deep, with the write sequencer behind it
// reset is synchronous: counters go to zero, both dimensions to one, all stages empty
module s4_symmetric_tensor_unpack #(
   parameter int MAX_DIM = s4stu_pkg::MAX_DIM_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [s4stu_pkg::REQ_DATA_W-1:0] req_tdata,   // element_bits
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [s4stu_pkg::RSP_DATA_W-1:0] rsp_tdata,   // write_data, write_address
   output logic                             rsp_tlast,   // last_write
   input  logic                             csr_we,
   input  logic [s4stu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [s4stu_pkg::DIM_W-1:0]      csr_wdata
);
   import s4stu_pkg::*;

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int DIMX_W = $clog2(MAX_DIM + 1);

   logic                          accept;
   logic [IDX_W-1:0]              idx_i, idx_j, idx_k, idx_l;
   logic [DIMX_W-1:0]             outer_eff, inner_eff;
   logic                          a_valid, a_ready;
   logic [ELEM_W-1:0]             a_bits;
   logic [WRITES-1:0][ADDR_W-1:0] a_addr;

   assign accept = req_tvalid && req_tready;

   s4stu_index #(.MAX_DIM(MAX_DIM)) u_index (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (accept),
      .idx_i     (idx_i),
      .idx_j     (idx_j),
      .idx_k     (idx_k),
      .idx_l     (idx_l),
      .outer_eff (outer_eff),
      .inner_eff (inner_eff)
   );

   s4stu_addr #(.MAX_DIM(MAX_DIM)) u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_bits   (req_tdata),
      .idx_i     (idx_i),
      .idx_j     (idx_j),
      .idx_k     (idx_k),
      .idx_l     (idx_l),
      .outer_eff (outer_eff),
      .inner_eff (inner_eff),
      .out_valid (a_valid),
      .out_ready (a_ready),
      .out_bits  (a_bits),
      .out_addr  (a_addr)
   );

   s4stu_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (a_valid),
      .load_ready (a_ready),
      .load_bits  (a_bits),
      .load_addr  (a_addr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/s4stu_checker.sv -----
module s4stu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [s4stu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);
   import s4stu_pkg::*;

   // nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("write offered after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled write changed");

   // the four writes of an element follow each other with no gap
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a write group");

   a_group_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tdata[RSP_DATA_W-1:ADDR_W] == $past(rsp_tdata[RSP_DATA_W-1:ADDR_W]))
      else $error("element bits changed inside a write group");

endmodule

bind s4_symmetric_tensor_unpack s4stu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- dv/s4_symmetric_tensor_unpack_test.sv -----
module s4_symmetric_tensor_unpack_test;
   timeunit 1ns;
   timeprecision 1ps;

   import s4stu_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 28;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [ELEM_W-1:0] data;
      logic              last;
   } tensor_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;     // element_bits
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // write_data, write_address
   logic                  rsp_tlast;          // last_write
   logic                  csr_we = 1'b0;
   csr_reg_type           csr_index = CSR_OUTER_DIM;
   logic [DIM_W-1:0]      csr_wdata = '0;

   // predictor state
   logic [DIM_W-1:0] outer_dim_reg = DIM_RESET;
   logic [DIM_W-1:0] inner_dim_reg = DIM_RESET;
   logic [5:0]       idx_i = '0;
   logic [5:0]       idx_j = '0;
   logic [5:0]       idx_k = '0;
   logic [5:0]       idx_l = '0;

   tensor_write_type pending_writes[$];
   tensor_write_type seen_write;
   tensor_write_type due_write;

   bit steady = 1'b0;
   int error_count = 0;
   int elements_sent = 0;
   int zero_elements = 0;
   int writes_checked = 0;
   int config_writes = 0;

   s4_symmetric_tensor_unpack u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("timeout with %0d writes still outstanding", pending_writes.size());
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [DIM_W-1:0] used_dim(input logic [DIM_W-1:0] reg_value);
      if (reg_value == '0) begin
         return 7'd1;
      end
      if (reg_value > MAX_DIM_DEF) begin
         return 7'(MAX_DIM_DEF);
      end
      return reg_value;
   endfunction

   function automatic logic [ADDR_W-1:0] flat_address(input logic [5:0] a, input logic [5:0] b,
                                                      input logic [5:0] c, input logic [5:0] d);
      int unsigned od;
      int unsigned id;
      int unsigned x;
      od = 32'(used_dim(outer_dim_reg));
      id = 32'(used_dim(inner_dim_reg));
      x = ((32'(a) * od + 32'(b)) * id + 32'(c)) * id + 32'(d);
      return x[ADDR_W-1:0];
   endfunction

   // expected writes for one accepted element, then step the index counters
   function automatic void unpack_element(input logic [ELEM_W-1:0] bits);
      logic [ADDR_W-1:0] addr [WRITES];
      tensor_write_type  w;
      addr[0] = flat_address(idx_i, idx_j, idx_k, idx_l);
      addr[1] = flat_address(idx_i, idx_j, idx_l, idx_k);
      addr[2] = flat_address(idx_j, idx_i, idx_l, idx_k);
      addr[3] = flat_address(idx_j, idx_i, idx_k, idx_l);
      if (bits[ELEM_W-2:0] != '0) begin
         for (int r = 0; r < WRITES; r++) begin
            w.address = addr[r];
            w.data    = bits;
            w.last    = (r == WRITES - 1);
            pending_writes.push_back(w);
         end
      end else begin
         zero_elements++;
      end
      if (idx_l < idx_k) begin
         idx_l++;
      end else begin
         idx_l = '0;
         if (7'(idx_k) + 7'd1 < used_dim(inner_dim_reg)) begin
            idx_k++;
         end else begin
            idx_k = '0;
            if (idx_j < idx_i) begin
               idx_j++;
            end else begin
               idx_j = '0;
               if (7'(idx_i) + 7'd1 < used_dim(outer_dim_reg)) begin
                  idx_i++;
               end else begin
                  idx_i = '0;
               end
            end
         end
      end
   endfunction

   function automatic logic [ELEM_W-1:0] random_element();
      logic [ELEM_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = 64'h8000_0000_0000_0000;
         2: v = {v[63], 11'h7FF, v[51:0]};
         3: v = 64'd1 << $urandom_range(0, 63);
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd127;
         2: return 7'd64;
         3: return 7'($urandom_range(65, 127));
         4: return 7'($urandom_range(5, 63));
         default: return 7'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic send_element(input logic [ELEM_W-1:0] bits);
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      unpack_element(bits);
      elements_sent++;
   endtask

   task automatic wait_drained(input int extra);
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_dim(input csr_reg_type which, input logic [DIM_W-1:0] value);
      wait_drained(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (which == CSR_OUTER_DIM) begin
         outer_dim_reg = value;
      end else begin
         inner_dim_reg = value;
      end
      config_writes++;
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_write.address = rsp_tdata[ADDR_W-1:0];
         seen_write.data    = rsp_tdata[ADDR_W+ELEM_W-1:ADDR_W];
         seen_write.last    = rsp_tlast;
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write addr %h data %h last %b",
                                      seen_write.address, seen_write.data, seen_write.last));
         end else begin
            due_write = pending_writes.pop_front();
            if (seen_write.address != due_write.address || seen_write.data != due_write.data
                || seen_write.last != due_write.last) begin
               report_mismatch($sformatf(
                  "write %0d: expected addr %h data %h last %b, got addr %h data %h last %b",
                  writes_checked, due_write.address, due_write.data, due_write.last,
                  seen_write.address, seen_write.data, seen_write.last));
            end
         end
         writes_checked++;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 14);
   end

   // dimensions left at their reset value of one: every nonzero element lands on address zero
   task automatic test_reset_dims();
      send_element({$urandom, $urandom} | 64'h1);
      send_element(64'h8000_0000_0000_0000);
      send_element(64'h7FF8_0000_0000_0000);
   endtask

   task automatic test_zero_and_special();
      send_element(64'h0000_0000_0000_0000);
      send_element(64'h0000_0000_0000_0001);
      send_element(64'h8000_0000_0000_0001);
      send_element(64'hFFFF_FFFF_FFFF_FFFF);
      send_element(64'h7FF0_0000_0000_0000);
      send_element(64'hFFF0_0000_0000_0001);
      send_element(64'h4000_0000_0000_0000);
   endtask

   // full pass over a 2x2x2x2 tensor, equal indices included, then the wrap
   task automatic test_small_sweep();
      write_dim(CSR_OUTER_DIM, 7'd2);
      write_dim(CSR_INNER_DIM, 7'd2);
      steady = 1'b1;
      repeat (10) send_element(random_element());
      steady = 1'b0;
   endtask

   // zero is used as one, anything above the maximum as the maximum
   task automatic test_dim_extremes();
      write_dim(CSR_OUTER_DIM, 7'd0);
      write_dim(CSR_INNER_DIM, 7'd127);
      repeat (3) send_element({$urandom, $urandom} | 64'h10);
      write_dim(CSR_OUTER_DIM, 7'd127);
      write_dim(CSR_INNER_DIM, 7'd0);
      repeat (3) send_element({$urandom, $urandom} | 64'h10);
   endtask

   // walk i well up with a unit inner size, widen the inner size for the high
   // address bits, then shrink the outer size so the counters run back from out of range
   task automatic test_outer_reach();
      int n;
      n = 0;
      write_dim(CSR_OUTER_DIM, 7'd64);
      write_dim(CSR_INNER_DIM, 7'd1);
      while (!(idx_i == 6'd15 && idx_j == 6'd0 && idx_k == 6'd0 && idx_l == 6'd0)) begin
         if (n % 48 == 47) begin
            send_element({$urandom, $urandom} | 64'h100);
         end else begin
            send_element({n[0], 63'd0});
         end
         n++;
      end
      write_dim(CSR_INNER_DIM, 7'd64);
      repeat (4) send_element(random_element() | 64'h1);
      write_dim(CSR_OUTER_DIM, 7'd4);
      write_dim(CSR_INNER_DIM, 7'd1);
      while (idx_i != 6'd0 || idx_j != 6'd0) begin
         send_element(($urandom_range(0, 3) == 0) ? random_element() : 64'h0);
      end
      repeat (3) send_element(random_element() | 64'h2);
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            write_dim(CSR_OUTER_DIM, 7'd3);
            write_dim(CSR_INNER_DIM, 7'd3);
         end else begin
            write_dim(CSR_OUTER_DIM, random_dim());
            write_dim(CSR_INNER_DIM, random_dim());
         end
         steady = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off until every outstanding write has come back or the drain limit runs out
            if (p == 3 && n == PHASE_ITEMS / 2) begin
               wait_drained(0);
            end
            send_element(random_element());
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_dims();
      test_zero_and_special();
      test_small_sweep();
      test_dim_extremes();
      test_outer_reach();
      test_random_phases();
      wait_drained(SETTLE_CYCLES);
      if (pending_writes.size() != 0) begin
         report_mismatch($sformatf("%0d expected writes never arrived", pending_writes.size()));
      end
      $display("sent %0d elements (%0d of them zero), checked %0d writes", elements_sent,
               zero_elements, writes_checked);
      $display("%0d dimension writes from 0 to 127, %0d mismatches", config_writes,
               error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
